/* hdl/pinhole_depth_projection_unit_defines.svh */
// Assertion macros shared by the pinhole projection RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef PINHOLE_DEPTH_PROJECTION_UNIT_DEFINES_SVH
`define PINHOLE_DEPTH_PROJECTION_UNIT_DEFINES_SVH

// same-cycle implication
`define PDP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdp assertion failed: same-cycle check");

// next-cycle implication
`define PDP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdp assertion failed: next-cycle check");

`endif

/* hdl/pdp_pkg.sv */
// Shared constants for the pinhole depth projection unit.
// No dependencies; used by the interfaces, the divider and the top level.
package pdp_pkg;

    localparam int DEF_IMAGE_WIDTH  = 640;
    localparam int DEF_IMAGE_HEIGHT = 480;

    localparam int COORD_W    = 32;  // Q23.8 point coordinates
    localparam int FOCAL_W    = 24;  // Q16.8
    localparam int CENTER_W   = 18;  // Q10.8
    localparam int DEPTH_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    // a*f + c*z + 128*z stays below 2^56 in magnitude
    localparam int NUM_W      = 58;

    // pixel fields of an output item; wider values are masked to these
    localparam int PIX_COL_W  = 10;
    localparam int PIX_ROW_W  = 9;
    localparam int PIX_IDX_W  = 19;

    localparam logic [FOCAL_W-1:0]  RST_FOCAL_X  = 24'd128000;
    localparam logic [FOCAL_W-1:0]  RST_FOCAL_Y  = 24'd128000;
    localparam logic [CENTER_W-1:0] RST_CENTER_X = 18'd81920;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y = 18'd61440;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;

endpackage

/* hdl/pdp_if.sv */
// Valid/ready stream interfaces for points in and projected pixels out.
// Depends on pdp_pkg for the coordinate, pixel and depth widths.
interface pdp_in_if import pdp_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface pdp_out_if import pdp_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 point_kept;
    logic                 in_view;
    logic [PIX_COL_W-1:0] pixel_col;
    logic [PIX_ROW_W-1:0] pixel_row;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [DEPTH_W-1:0]   depth_value;

    modport source (output valid, point_kept, in_view, pixel_col, pixel_row, pixel_index,
                    depth_value, input ready);
    modport sink   (input valid, point_kept, in_view, pixel_col, pixel_row, pixel_index,
                    depth_value, output ready);
endinterface

/* hdl/pdp_divider.sv */
// Pipelined restoring divider: floor(num / (256*z)) = round(n / (256*z)) for one axis.
// One range-check stage, then one quotient bit per stage. Uses pdp_pkg.
module pdp_divider import pdp_pkg::*; #(
    parameter int QB = 10
) (
    input  logic                    clk,
    input  logic [QB:0]             en,
    input  logic signed [NUM_W-1:0] num,   // n + 128*z
    input  logic                    neg,   // n < 0
    input  logic [COORD_W-1:0]      z,
    output logic [QB-1:0]           quot,
    output logic                    ovf
);

    logic [NUM_W-1:0]   rem_reg [0:QB];
    logic [COORD_W-1:0] z_reg   [0:QB-1];
    logic [QB-1:0]      q_reg   [0:QB];
    logic               ovf_reg [0:QB];

    logic [NUM_W-1:0] lim;
    logic             ovf_next;
    logic [NUM_W-1:0] rem_next;

    // Negative n: the quotient rounds to 0 only when |n| < 128*z, i.e. num > 0.
    always_comb
    begin
        lim = NUM_W'(z) << (8 + QB);
        if (neg)
        begin
            ovf_next = num[NUM_W-1] || (num == '0);
            rem_next = '0;
        end
        else
        begin
            ovf_next = (NUM_W'(num) >= lim);
            rem_next = NUM_W'(num);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= rem_next;
            z_reg[0]   <= z;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        logic [NUM_W-1:0] dsh;
        logic [NUM_W:0]   trial;
        logic             bit_q;

        always_comb
        begin
            dsh   = NUM_W'(z_reg[j-1]) << (8 + QB - j);
            trial = {1'b0, rem_reg[j-1]} - {1'b0, dsh};
            bit_q = ~trial[NUM_W];
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= bit_q ? trial[NUM_W-1:0] : rem_reg[j-1];
                q_reg[j]   <= {q_reg[j-1][QB-2:0], bit_q};
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end

        if (j < QB)
        begin : g_z
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    z_reg[j] <= z_reg[j-1];
                end
            end
        end
    end

    assign quot = q_reg[QB];
    assign ovf  = ovf_reg[QB];

endmodule

/* hdl/pinhole_depth_projection_unit.sv */
// Pinhole depth projection: one point (Q23.8) in, one pixel result out, one item per
// cycle sustained while pixels.ready holds. Stages: a multiply stage, a sum stage, a
// range-check stage, one restoring-divider stage per quotient bit, with QB =
// clog2(max(IMAGE_WIDTH, IMAGE_HEIGHT)) quotient bits, and an output stage. Stalls back
// up stage by stage, so bubbles close up while the output waits. Configuration is taken
// at any cycle through cfg_we/cfg_index/cfg_data and applies to items accepted later.
`include "pinhole_depth_projection_unit_defines.svh"

module pinhole_depth_projection_unit import pdp_pkg::*; #(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pdp_in_if.sink                points,
    pdp_out_if.source             pixels
);

    localparam int COL_W   = PIX_COL_W;
    localparam int ROW_W   = PIX_ROW_W;
    localparam int IDX_W   = PIX_IDX_W;
    localparam int DIM_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int QB      = $clog2(DIM_MAX);
    localparam int NST     = QB + 4;
    localparam int LAST    = NST - 1;
    // full linear index before masking: row*W + col < 2^(2*QB+1)
    localparam int LIN_W   = 2 * QB + 1;

    // configuration
    logic [FOCAL_W-1:0]  focal_x_reg, focal_y_reg;
    logic [CENTER_W-1:0] center_x_reg, center_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= RST_FOCAL_X;
            focal_y_reg  <= RST_FOCAL_Y;
            center_x_reg <= RST_CENTER_X;
            center_y_reg <= RST_CENTER_Y;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FOCAL_X:  focal_x_reg  <= cfg_data[FOCAL_W-1:0];
                REG_FOCAL_Y:  focal_y_reg  <= cfg_data[FOCAL_W-1:0];
                REG_CENTER_X: center_x_reg <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control: a stage moves when it is empty or the next one moves
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[LAST] = !v_reg[LAST] || pixels.ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign points.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= points.valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 0: products, keep flag, rounded depth
    logic signed [NUM_W-1:0]   pa_col_reg, pc_col_reg, pa_row_reg, pc_row_reg;
    logic signed [COORD_W-1:0] z0_reg;
    logic                      kept_pipe_reg  [0:LAST-1];
    logic [DEPTH_W-1:0]        depth_pipe_reg [0:LAST-1];

    logic [COORD_W:0]   zr;
    logic               kept_next;
    logic [DEPTH_W-1:0] depth_next;

    always_comb
    begin
        kept_next = !points.point_z[COORD_W-1] && (points.point_z != '0);
        zr        = {1'b0, points.point_z} + (COORD_W+1)'(128);
        if (!kept_next)
        begin
            depth_next = '0;
        end
        else if (zr[COORD_W:8] > (COORD_W-7)'(65535))
        begin
            depth_next = '1;
        end
        else
        begin
            depth_next = zr[DEPTH_W+7:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pa_col_reg        <= NUM_W'(points.point_x) * NUM_W'($signed({1'b0, focal_x_reg}));
            pc_col_reg        <= NUM_W'($signed({1'b0, center_x_reg})) * NUM_W'(points.point_z);
            pa_row_reg        <= NUM_W'(points.point_y) * NUM_W'($signed({1'b0, focal_y_reg}));
            pc_row_reg        <= NUM_W'($signed({1'b0, center_y_reg})) * NUM_W'(points.point_z);
            z0_reg            <= points.point_z;
            kept_pipe_reg[0]  <= kept_next;
            depth_pipe_reg[0] <= depth_next;
        end
    end

    for (genvar i = 1; i < LAST; i++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                kept_pipe_reg[i]  <= kept_pipe_reg[i-1];
                depth_pipe_reg[i] <= depth_pipe_reg[i-1];
            end
        end
    end

    // stage 1: numerator n = a*f + c*z and shifted numerator n + 128*z
    logic signed [NUM_W-1:0]   num_col_reg, num_row_reg;
    logic                      neg_col_reg, neg_row_reg;
    logic signed [COORD_W-1:0] z1_reg;
    logic signed [NUM_W-1:0]   n_col, n_row, z128;

    always_comb
    begin
        n_col = pa_col_reg + pc_col_reg;
        n_row = pa_row_reg + pc_row_reg;
        z128  = NUM_W'(z0_reg) <<< 7;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            num_col_reg <= pa_col_reg + pc_col_reg + z128;
            num_row_reg <= pa_row_reg + pc_row_reg + z128;
            neg_col_reg <= n_col[NUM_W-1];
            neg_row_reg <= n_row[NUM_W-1];
            z1_reg      <= z0_reg;
        end
    end

    // stages 2 .. QB+2: dividers
    logic [QB-1:0] col_q, row_q;
    logic          col_ovf, row_ovf;

    pdp_divider #(.QB(QB)) u_div_col (
        .clk  (clk),
        .en   (en[QB+2:2]),
        .num  (num_col_reg),
        .neg  (neg_col_reg),
        .z    (z1_reg),
        .quot (col_q),
        .ovf  (col_ovf)
    );

    pdp_divider #(.QB(QB)) u_div_row (
        .clk  (clk),
        .en   (en[QB+2:2]),
        .num  (num_row_reg),
        .neg  (neg_row_reg),
        .z    (z1_reg),
        .quot (row_q),
        .ovf  (row_ovf)
    );

    // output stage: bounds check and linear index
    logic               kept_o_reg, view_o_reg;
    logic [COL_W-1:0]   col_o_reg;
    logic [ROW_W-1:0]   row_o_reg;
    logic [IDX_W-1:0]   idx_o_reg;
    logic [DEPTH_W-1:0] depth_o_reg;

    logic          view_next;
    logic [QB-1:0] col_next;
    logic [QB-1:0] row_next;

    always_comb
    begin
        view_next = kept_pipe_reg[LAST-1] && !col_ovf && !row_ovf
                    && ({1'b0, col_q} < (QB+1)'(IMAGE_WIDTH))
                    && ({1'b0, row_q} < (QB+1)'(IMAGE_HEIGHT));
        col_next  = view_next ? col_q : '0;
        row_next  = view_next ? row_q : '0;
    end

    // index from the full row and column, then masked to the field width
    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            kept_o_reg  <= kept_pipe_reg[LAST-1];
            view_o_reg  <= view_next;
            col_o_reg   <= COL_W'(col_next);
            row_o_reg   <= ROW_W'(row_next);
            idx_o_reg   <= IDX_W'(LIN_W'(row_next) * LIN_W'(IMAGE_WIDTH) + LIN_W'(col_next));
            depth_o_reg <= depth_pipe_reg[LAST-1];
        end
    end

    assign pixels.valid       = v_reg[LAST];
    assign pixels.point_kept  = kept_o_reg;
    assign pixels.in_view     = view_o_reg;
    assign pixels.pixel_col   = col_o_reg;
    assign pixels.pixel_row   = row_o_reg;
    assign pixels.pixel_index = idx_o_reg;
    assign pixels.depth_value = depth_o_reg;

    // an item in the stage before the output moves in when the output stage is free
    `PDP_ASSERT_NXT(a_out_fill, v_reg[LAST-1] && en[LAST], v_reg[LAST])
    // a dropped point carries no pixel and no depth
    `PDP_ASSERT_IMP(a_drop_clean, pixels.valid && !pixels.point_kept,
                    !pixels.in_view && (pixels.depth_value == '0))
    // pixels on the sensor lie inside its bounds
    `PDP_ASSERT_IMP(a_view_bounds, pixels.valid && pixels.in_view,
                    (32'(pixels.pixel_col) < 32'(IMAGE_WIDTH)) &&
                    (32'(pixels.pixel_row) < 32'(IMAGE_HEIGHT)))
    // a waiting result is not overwritten
    `PDP_ASSERT_NXT(a_out_hold, pixels.valid && !pixels.ready,
                    pixels.valid && $stable(idx_o_reg) && $stable(depth_o_reg))

endmodule
